@@ rtl/dlsq_pkg.sv @@
`default_nettype none
package dlsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 16;
    localparam int TASK_BITS   = 8;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // request opcodes
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // one stored queue entry
    typedef struct packed {
        logic [TIME_BITS-1:0] delta;
        logic [TASK_BITS-1:0] task_id;
    } entry_t;

    // insert token walking down the chain
    // shift = 0: still searching, delta is the remaining wait
    // shift = 1: entry already placed, carrying the displaced entry
    typedef struct packed {
        logic                 valid;
        logic                 shift;
        logic [TIME_BITS-1:0] delta;
        logic [TASK_BITS-1:0] task_id;
    } token_t;

    // per-cell command from the sequencer
    typedef struct packed {
        logic pop;  // take the next cell's entry
        logic dec;  // decrement own delta
    } cell_cmd_t;

endpackage
`default_nettype wire

@@ rtl/dlsq_cell.sv @@
`default_nettype none
module dlsq_cell (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       occupied,
    input  wire dlsq_pkg::cell_cmd_t  cmd,
    input  wire dlsq_pkg::token_t     tok_in,
    output dlsq_pkg::token_t          tok_out,
    input  wire dlsq_pkg::entry_t     nbr_entry,
    output dlsq_pkg::entry_t          entry,
    output logic                      done
);

    dlsq_pkg::entry_t entry_reg;
    dlsq_pkg::entry_t entry_next;
    dlsq_pkg::token_t tok_reg;

    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        tok_out    = '0;
        done       = 1'b0;
        if (cmd.pop) begin
            entry_next = nbr_entry;
        end else if (cmd.dec) begin
            entry_next.delta = entry_reg.delta - dlsq_pkg::TIME_BITS'(1);
        end else if (tok_reg.valid) begin
            if (!occupied) begin
                // end of the list: the token settles here
                entry_next.delta   = tok_reg.delta;
                entry_next.task_id = tok_reg.task_id;
                done               = 1'b1;
            end else if (tok_reg.shift) begin
                entry_next.delta   = tok_reg.delta;
                entry_next.task_id = tok_reg.task_id;
                tok_out = '{valid: 1'b1, shift: 1'b1,
                            delta: entry_reg.delta, task_id: entry_reg.task_id};
            end else if (tok_reg.delta >= entry_reg.delta) begin
                // goes after this entry (ties go behind)
                tok_out = '{valid: 1'b1, shift: 1'b0,
                            delta: tok_reg.delta - entry_reg.delta,
                            task_id: tok_reg.task_id};
            end else begin
                // place here, follower's delta shrinks by the new delta
                entry_next.delta   = tok_reg.delta;
                entry_next.task_id = tok_reg.task_id;
                tok_out = '{valid: 1'b1, shift: 1'b1,
                            delta: entry_reg.delta - tok_reg.delta,
                            task_id: entry_reg.task_id};
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        tok_reg.shift   <= tok_in.shift;
        tok_reg.delta   <= tok_in.delta;
        tok_reg.task_id <= tok_in.task_id;
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_in.valid;
        end
    end

endmodule
`default_nettype wire

@@ rtl/delta_list_sleep_queue.sv @@
`default_nettype none
// Sleep queue kept as a delta list in a chain of QUEUE_DEPTH cells: each cell holds one
// task id and its wait relative to the entry in front of it; cell 0 is the head and its
// delta is absolute. Requests are taken one at a time (s_ready is high only when the
// block is idle). An insert request (op 0) sends a token down the chain, one cell per
// cycle; the token drops its wait by each delta it passes, settles behind all entries
// with an equal or smaller total wait, then ripples the displaced entries one cell back.
// An insert yields one result: woken 0, last 1, queue_full set when the queue was
// already full (queue unchanged). A tick request (op 1) pops every head with zero
// delta, one per cycle unless a stalled result holds the output, the whole chain
// shifting one cell toward the head, giving one result per woken task with last on the
// final one, then decrements the new head. A tick that wakes nothing gives one result
// with woken 0 and last 1. The output register lets a new request be accepted while the
// previous result is still waiting.
module delta_list_sleep_queue (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_op,
    input  wire  [7:0]  s_task_id,
    input  wire  [15:0] s_sleep_time,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_woken_task,
    output logic        m_woken,
    output logic        m_queue_full,
    output logic        m_last
);

    localparam int D = dlsq_pkg::QUEUE_DEPTH;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INSERT = 4'b0010,
        ST_TICK   = 4'b0100,
        ST_REPLY  = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [dlsq_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          full_reg, full_next;
    logic                          woke_reg, woke_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    m_task_reg, m_task_next;
    logic                          m_woken_reg, m_woken_next;
    logic                          m_full_reg, m_full_next;
    logic                          m_last_reg, m_last_next;

    // chain wiring
    dlsq_pkg::token_t              tok [D+1];
    dlsq_pkg::entry_t              ent [D];
    dlsq_pkg::cell_cmd_t           cmd [D];
    logic [D-1:0]                  occ;
    logic [D-1:0]                  done_vec;

    logic                          accept;
    logic                          out_free;
    logic                          queue_full;
    logic                          head_zero;
    logic                          next_zero;
    logic                          pop;
    logic                          dec;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign queue_full   = (count_reg == dlsq_pkg::COUNT_W'(D));

    assign m_valid      = m_valid_reg;
    assign m_woken_task = m_task_reg;
    assign m_woken      = m_woken_reg;
    assign m_queue_full = m_full_reg;
    assign m_last       = m_last_reg;

    // head status for the tick walk
    assign head_zero = occ[0] && (ent[0].delta == '0);
    assign next_zero = occ[1] && (ent[1].delta == '0);

    // token injected into cell 0 on an accepted insert
    assign tok[0] = '{valid: accept && (s_op == dlsq_pkg::OP_SLEEP) && !queue_full,
                      shift: 1'b0,
                      delta: dlsq_pkg::TIME_BITS'(s_sleep_time), task_id: s_task_id};

    genvar i;
    generate
        for (i = 0; i < D; i++) begin : g_cell
            dlsq_pkg::entry_t nbr;
            if (i == D - 1) begin : g_tail
                assign nbr = ent[i];
            end else begin : g_mid
                assign nbr = ent[i+1];
            end

            assign occ[i]     = (dlsq_pkg::COUNT_W'(i) < count_reg);
            assign cmd[i].pop = pop;
            assign cmd[i].dec = (i == 0) ? dec : 1'b0;

            dlsq_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .occupied  (occ[i]),
                .cmd       (cmd[i]),
                .tok_in    (tok[i]),
                .tok_out   (tok[i+1]),
                .nbr_entry (nbr),
                .entry     (ent[i]),
                .done      (done_vec[i])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        full_next    = full_reg;
        woke_next    = woke_reg;
        pop          = 1'b0;
        dec          = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_task_next  = m_task_reg;
        m_woken_next = m_woken_reg;
        m_full_next  = m_full_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    woke_next = 1'b0;
                    full_next = queue_full;
                    if (s_op == dlsq_pkg::OP_TICK) begin
                        state_next = ST_TICK;
                    end else if (queue_full) begin
                        state_next = ST_REPLY;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                // wait for the token to settle at the end of the list
                if (|done_vec) begin
                    count_next = count_reg + dlsq_pkg::COUNT_W'(1);
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_task_next  = '0;
                    m_woken_next = 1'b0;
                    m_full_next  = full_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (head_zero) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_task_next  = ent[0].task_id;
                        m_woken_next = 1'b1;
                        m_full_next  = 1'b0;
                        m_last_next  = !next_zero;
                        pop          = 1'b1;
                        woke_next    = 1'b1;
                        count_next   = count_reg - dlsq_pkg::COUNT_W'(1);
                    end
                end else if (woke_reg) begin
                    dec        = occ[0];
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // nothing woke: single empty result
                    m_valid_next = 1'b1;
                    m_task_next  = '0;
                    m_woken_next = 1'b0;
                    m_full_next  = 1'b0;
                    m_last_next  = 1'b1;
                    dec          = occ[0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        full_reg    <= full_next;
        woke_reg    <= woke_next;
        m_task_reg  <= m_task_next;
        m_woken_reg <= m_woken_next;
        m_full_reg  <= m_full_next;
        m_last_reg  <= m_last_next;
    end

endmodule
`default_nettype wire

@@ rtl/dlsq_checker.sv @@
`default_nettype none
module dlsq_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire  [7:0] m_woken_task,
    input wire        m_woken,
    input wire        m_queue_full,
    input wire        m_last
);

    // one request at a time: ready drops right after an accept
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_woken_task) && $stable(m_woken)
            && $stable(m_queue_full) && $stable(m_last))
        else $error("stalled result changed");

    // a result with no woken task always closes its request
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_woken |-> m_last)
        else $error("non-woken result without last");

    // a refused insert never reports a woken task
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_queue_full |-> !m_woken && m_last)
        else $error("queue_full on a wake result");

    // task id is zero when nothing woke
    a_task_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_woken |-> m_woken_task == 8'd0)
        else $error("task id set without woken");

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_woken_task (m_woken_task),
    .m_woken      (m_woken),
    .m_queue_full (m_queue_full),
    .m_last       (m_last)
);
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Sleep queue testbench.
// Requests go in one at a time over the s_ handshake. A behavioral copy of the delta list
// lives in the bench and is updated on every accepted request. That copy queues up the
// wakeup results the block should give. The checker takes each m_ handshake and compares
// it field by field against the oldest queued result.
module tb_top;

    localparam int CYCLE_LIMIT  = 600_000;  // far beyond the slowest legal run
    localparam int DRAIN_CYCLES = 40;       // > a full 16-wake tick plus margin

    // one result beat as the block presents it
    typedef struct packed {
        logic [dlsq_pkg::TASK_BITS-1:0] woken_task;
        logic                           woken;
        logic                           queue_full;
        logic                           last;
    } wake_result_t;

    logic                           aclk;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_op         = 1'b0;
    logic [dlsq_pkg::TASK_BITS-1:0] s_task_id    = '0;
    logic [dlsq_pkg::TIME_BITS-1:0] s_sleep_time = '0;
    logic                           m_ready      = 1'b0;
    logic                           s_ready;
    logic                           m_valid;
    logic [dlsq_pkg::TASK_BITS-1:0] m_woken_task;
    logic                           m_woken;
    logic                           m_queue_full;
    logic                           m_last;

    // bench copy of the delta list
    logic [dlsq_pkg::TIME_BITS-1:0] sleepq_delta [dlsq_pkg::QUEUE_DEPTH];
    logic [dlsq_pkg::TASK_BITS-1:0] sleepq_task  [dlsq_pkg::QUEUE_DEPTH];
    int                             sleepq_count = 0;

    wake_result_t expected_wakeups[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;  // chance per cycle that the sender holds off
    int recv_idle_pct = 0;  // chance per cycle that m_ready is low

    delta_list_sleep_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_task_id   (s_task_id),
        .s_sleep_time(s_sleep_time),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_woken_task(m_woken_task),
        .m_woken     (m_woken),
        .m_queue_full(m_queue_full),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------

    // Walk past every entry whose total wait is <= the new one, place it there,
    // and take its remaining wait out of the entry behind it. Full queue: refuse.
    function automatic void sleepq_insert(input logic [dlsq_pkg::TASK_BITS-1:0] id,
                                          input logic [dlsq_pkg::TIME_BITS-1:0] ticks);
        logic [dlsq_pkg::TIME_BITS-1:0] remain;
        int                             pos;
        int                             i;
        logic                           accepted;
        remain   = ticks;
        pos      = 0;
        accepted = (sleepq_count < dlsq_pkg::QUEUE_DEPTH);
        if (accepted) begin
            while (pos < sleepq_count && remain >= sleepq_delta[pos]) begin
                remain = remain - sleepq_delta[pos];
                pos++;
            end
            for (i = sleepq_count; i > pos; i--) begin
                sleepq_delta[i] = sleepq_delta[i-1];
                sleepq_task[i]  = sleepq_task[i-1];
            end
            sleepq_delta[pos] = remain;
            sleepq_task[pos]  = id;
            sleepq_count++;
            if (pos + 1 < sleepq_count)
                sleepq_delta[pos+1] = sleepq_delta[pos+1] - remain;
        end
        expected_wakeups.push_back('{'0, 1'b0, !accepted, 1'b1});
    endfunction

    // Pop every head at zero delta, then count the new head down by one.
    function automatic void sleepq_tick();
        logic [dlsq_pkg::TASK_BITS-1:0] woke[$];
        int                             i;
        while (sleepq_count > 0 && sleepq_delta[0] == '0) begin
            woke.push_back(sleepq_task[0]);
            for (i = 1; i < sleepq_count; i++) begin
                sleepq_delta[i-1] = sleepq_delta[i];
                sleepq_task[i-1]  = sleepq_task[i];
            end
            sleepq_count--;
        end
        if (sleepq_count > 0)
            sleepq_delta[0] = sleepq_delta[0] - 1'b1;
        if (woke.size() == 0)
            expected_wakeups.push_back('{'0, 1'b0, 1'b0, 1'b1});
        for (i = 0; i < woke.size(); i++)
            expected_wakeups.push_back('{woke[i], 1'b1, 1'b0, i == woke.size() - 1});
    endfunction

    //------------------------------------------------------------------
    // Result side
    //------------------------------------------------------------------

    // random backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // values read here are the ones from before the edge
    always @(posedge aclk) begin : result_checker
        wake_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_wakeups.size() == 0) begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual task %0h woken %0b full %0b last %0b"},
                         $time, m_woken_task, m_woken, m_queue_full, m_last);
                error_count++;
            end else begin
                want = expected_wakeups.pop_front();
                check_field("woken_task", 32'(want.woken_task), 32'(m_woken_task));
                check_field("woken",      32'(want.woken),      32'(m_woken));
                check_field("queue_full", 32'(want.queue_full), 32'(m_queue_full));
                check_field("last",       32'(want.last),       32'(m_last));
            end
        end
    end

    //------------------------------------------------------------------
    // Request side
    //------------------------------------------------------------------

    // Called just after a rising edge. Valid drops only during an idle gap, so s_valid
    // never gets two assignments in one step.
    task automatic send_request(input logic op, input logic [dlsq_pkg::TASK_BITS-1:0] id,
                                input logic [dlsq_pkg::TIME_BITS-1:0] ticks);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_task_id    <= id;
        s_sleep_time <= ticks;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == dlsq_pkg::OP_SLEEP)
            sleepq_insert(id, ticks);
        else
            sleepq_tick();
    endtask

    // hold off until every queued result has come out
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_wakeups.size() != 0);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Fill from empty with zero waits (all ties, kept in arrival order), get one refusal,
    // then a single tick wakes the whole queue: the longest burst, with last on the end.
    task automatic test_full_queue_wakes_all();
        int k;
        for (k = 0; k < dlsq_pkg::QUEUE_DEPTH; k++)
            send_request(dlsq_pkg::OP_SLEEP, dlsq_pkg::TASK_BITS'(k + 8'h10), '0);
        send_request(dlsq_pkg::OP_SLEEP, 8'hEE, 16'd5);
        wait_until_drained();
        send_request(dlsq_pkg::OP_TICK, '0, '0);
    endtask

    // Empty tick, field extremes, equal waits, zero wait, ticks that wake none/one/two.
    task automatic test_directed_cases();
        send_request(dlsq_pkg::OP_TICK,  8'h00, 16'h0000);  // empty: nothing to count down
        send_request(dlsq_pkg::OP_SLEEP, 8'hFF, 16'hFFFF);
        send_request(dlsq_pkg::OP_SLEEP, 8'h00, 16'h0000);  // goes to head
        send_request(dlsq_pkg::OP_SLEEP, 8'h5A, 16'd3);
        send_request(dlsq_pkg::OP_SLEEP, 8'hA5, 16'd3);     // tie: lands behind 0x5A
        send_request(dlsq_pkg::OP_TICK,  8'h00, 16'h0000);  // wakes 0x00
        send_request(dlsq_pkg::OP_TICK,  8'hFF, 16'hFFFF);  // wakes nothing
        send_request(dlsq_pkg::OP_TICK,  8'h00, 16'h0000);
        send_request(dlsq_pkg::OP_TICK,  8'h00, 16'h0000);  // wakes 0x5A then 0xA5
    endtask

    // Mostly short waits so ticks keep waking tasks and the queue cycles through
    // empty and full; a few long ones sit at the tail and take up slots.
    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int recv_pct);
        int                             k;
        int                             pick;
        logic [dlsq_pkg::TIME_BITS-1:0] ticks;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 3)
                wait_until_drained();
            pick = $urandom_range(99);
            if (pick < 75)
                ticks = dlsq_pkg::TIME_BITS'($urandom_range(7));
            else if (pick < 96)
                ticks = dlsq_pkg::TIME_BITS'($urandom_range(255));
            else
                ticks = dlsq_pkg::TIME_BITS'($urandom_range(65535));
            if ($urandom_range(99) < 45)
                send_request(dlsq_pkg::OP_TICK, dlsq_pkg::TASK_BITS'($urandom_range(255)),
                             dlsq_pkg::TIME_BITS'($urandom_range(65535)));
            else
                send_request(dlsq_pkg::OP_SLEEP, dlsq_pkg::TASK_BITS'($urandom_range(255)),
                             ticks);
        end
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_full_queue_wakes_all();
        test_directed_cases();
        test_random_traffic(81, 10, 81);
        test_random_traffic(81, 81, 10);
        test_random_traffic(81, 0, 0);

        s_valid <= 1'b0;
        while (expected_wakeups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);  // catch stray results

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
